@@ hdl/terminal_line_editor_assert.svh @@
// Assertion macros for the terminal line editor.
// Depends on nothing; included by the modules that assert.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication: cons must hold whenever ante holds.
`define TLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("terminal_line_editor assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define TLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("terminal_line_editor assertion failed");
`else
`define TLE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/tle_pkg.sv @@
// Shared types and constants of the terminal line editor.
// Depends on nothing; used by tle_ctrl and terminal_line_editor.
package tle_pkg;

    // Operation codes of an input item.
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Result kinds.
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // Terminal characters.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_UP    = 8'h41;  // 'A'
    localparam logic [7:0] CH_RIGHT = 8'h43;  // 'C'
    localparam logic [7:0] CH_LEFT  = 8'h44;  // 'D'

    // Control of one memory port pair.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

@@ hdl/tle_bank_mem.sv @@
// One byte bank of the line editor: synchronous RAM with a registered read
// and per-entry valid bits so that unwritten or cleared entries read as zero.
// Depends on nothing.
module tle_bank_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 8'h00;

endmodule

@@ hdl/tle_ctrl.sv @@
// Sequencer of the line editor: decodes items, walks the line and history
// banks one byte a cycle unless stalled, drives the result register. Depends on tle_pkg.
`include "terminal_line_editor_assert.svh"

module tle_ctrl #(
    parameter int LINE_BYTES = 64,
    parameter int AW         = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [7:0]         i_rx_byte,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_kind,
    output logic [7:0]         o_out_byte,
    output logic               o_last,
    // line bank
    output tle_pkg::t_mem_ctl  o_line_ctl,
    output logic [AW-1:0]      o_line_wr_addr,
    output logic [7:0]         o_line_wr_data,
    output logic [AW-1:0]      o_line_rd_addr,
    input  logic [7:0]         i_line_rd_data,
    // history bank
    output logic               o_hist_rd_en,
    output logic [AW-1:0]      o_hist_rd_addr,
    input  logic [7:0]         i_hist_rd_data,
    // exchange line and history banks, clear the new line bank
    output logic               o_swap
);

    localparam logic [AW-1:0] LAST_POS = AW'(LINE_BYTES - 1);
    localparam logic [AW-1:0] ONE_A    = AW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RIGHT,
        S_RECALL,
        S_DELIV,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SEQ_ONE,
        SEQ_BSSPBS,
        SEQ_CRLF
    } t_seq;

    t_state        r_state, n_state;
    t_seq          r_seq, n_seq;
    logic [1:0]    r_step, n_step;
    logic [7:0]    r_byte, n_byte;
    logic [AW-1:0] r_cursor, n_cursor;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_line_ready, n_line_ready;
    logic          r_esc, n_esc;
    logic          r_drop, n_drop;
    logic [7:0]    r_hold, n_hold;
    logic          r_hold_valid, n_hold_valid;
    logic          r_out_valid, n_out_valid;
    logic          r_out_kind, n_out_kind;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;

    logic          can_push;
    logic          push;
    logic          push_kind;
    logic [7:0]    push_byte;
    logic          push_last;

    function automatic logic [7:0] seq_byte(t_seq seq, logic [1:0] step, logic [7:0] b);
        logic [7:0] res;
        res = b;
        case (seq)
            SEQ_ONE:    res = b;
            SEQ_BSSPBS: res = (step == 2'd1) ? tle_pkg::CH_SP : tle_pkg::CH_BS;
            SEQ_CRLF:   res = (step == 2'd0) ? tle_pkg::CH_CR : tle_pkg::CH_LF;
            default:    res = b;
        endcase
        return res;
    endfunction

    function automatic logic seq_last(t_seq seq, logic [1:0] step);
        logic res;
        res = 1'b1;
        case (seq)
            SEQ_ONE:    res = 1'b1;
            SEQ_BSSPBS: res = (step == 2'd2);
            SEQ_CRLF:   res = (step == 2'd1);
            default:    res = 1'b1;
        endcase
        return res;
    endfunction

    assign can_push = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_seq        = r_seq;
        n_step       = r_step;
        n_byte       = r_byte;
        n_cursor     = r_cursor;
        n_idx        = r_idx;
        n_line_ready = r_line_ready;
        n_esc        = r_esc;
        n_drop       = r_drop;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;

        o_line_ctl     = '0;
        o_line_wr_addr = r_cursor;
        o_line_wr_data = tle_pkg::CH_NUL;
        o_line_rd_addr = r_cursor;
        o_hist_rd_en   = 1'b0;
        o_hist_rd_addr = r_idx + ONE_A;
        o_swap         = 1'b0;

        push      = 1'b0;
        push_kind = tle_pkg::KIND_ECHO;
        push_byte = tle_pkg::CH_NUL;
        push_last = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == tle_pkg::OP_TAKE) begin
                        if (r_line_ready) begin
                            n_idx             = '0;
                            o_line_ctl.rd_en  = 1'b1;
                            o_line_rd_addr    = '0;
                            n_state           = S_DELIV;
                        end
                    end else if (r_drop) begin
                        n_drop = 1'b0;
                    end else if (r_line_ready) begin
                        n_state = S_IDLE;
                    end else if (r_esc) begin
                        n_esc = 1'b0;
                        case (i_rx_byte)
                            tle_pkg::CH_UP: begin
                                n_idx          = '0;
                                n_hold_valid   = 1'b0;
                                o_hist_rd_en   = 1'b1;
                                o_hist_rd_addr = '0;
                                n_state        = S_RECALL;
                            end
                            tle_pkg::CH_LEFT: begin
                                if (r_cursor != '0) begin
                                    n_cursor = r_cursor - ONE_A;
                                    n_seq    = SEQ_ONE;
                                    n_byte   = tle_pkg::CH_BS;
                                    n_step   = 2'd0;
                                    n_state  = S_EMIT;
                                end
                            end
                            tle_pkg::CH_RIGHT: begin
                                if (r_cursor != LAST_POS) begin
                                    o_line_ctl.rd_en = 1'b1;
                                    n_state          = S_RIGHT;
                                end
                            end
                            default: n_state = S_IDLE;
                        endcase
                    end else begin
                        case (i_rx_byte)
                            tle_pkg::CH_BS, tle_pkg::CH_DEL: begin
                                if (r_cursor != '0) begin
                                    o_line_ctl.wr_en = 1'b1;
                                    o_line_wr_addr   = r_cursor - ONE_A;
                                    n_cursor         = r_cursor - ONE_A;
                                    n_seq            = SEQ_BSSPBS;
                                    n_step           = 2'd0;
                                    n_state          = S_EMIT;
                                end
                            end
                            tle_pkg::CH_ESC: begin
                                n_drop = 1'b1;
                                n_esc  = 1'b1;
                            end
                            tle_pkg::CH_CR, tle_pkg::CH_LF: begin
                                n_line_ready = 1'b1;
                                n_cursor     = '0;
                                n_seq        = SEQ_CRLF;
                                n_step       = 2'd0;
                                n_state      = S_EMIT;
                            end
                            default: begin
                                if (i_rx_byte >= tle_pkg::CH_SP
                                        && i_rx_byte <= tle_pkg::CH_TILDE
                                        && r_cursor != LAST_POS) begin
                                    o_line_ctl.wr_en = 1'b1;
                                    o_line_wr_data   = i_rx_byte;
                                    n_cursor         = r_cursor + ONE_A;
                                    n_seq            = SEQ_ONE;
                                    n_byte           = i_rx_byte;
                                    n_step           = 2'd0;
                                    n_state          = S_EMIT;
                                end
                            end
                        endcase
                    end
                end
            end

            S_RIGHT: begin
                if (i_line_rd_data != tle_pkg::CH_NUL) begin
                    n_cursor = r_cursor + ONE_A;
                    n_seq    = SEQ_ONE;
                    n_byte   = i_line_rd_data;
                    n_step   = 2'd0;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_RECALL: begin
                // hold one byte back so the final echo can carry last
                if (r_cursor != LAST_POS && i_hist_rd_data != tle_pkg::CH_NUL) begin
                    if (!r_hold_valid || can_push) begin
                        push             = r_hold_valid;
                        push_byte        = r_hold;
                        o_line_ctl.wr_en = 1'b1;
                        o_line_wr_data   = i_hist_rd_data;
                        n_cursor         = r_cursor + ONE_A;
                        n_hold           = i_hist_rd_data;
                        n_hold_valid     = 1'b1;
                        n_idx            = r_idx + ONE_A;
                        o_hist_rd_en     = 1'b1;
                    end
                end else if (!r_hold_valid) begin
                    o_line_ctl.wr_en = 1'b1;
                    n_state          = S_IDLE;
                end else if (can_push) begin
                    o_line_ctl.wr_en = 1'b1;
                    push             = 1'b1;
                    push_byte        = r_hold;
                    push_last        = 1'b1;
                    n_hold_valid     = 1'b0;
                    n_state          = S_IDLE;
                end
            end

            S_DELIV: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_kind = tle_pkg::KIND_LINE;
                    if (i_line_rd_data != tle_pkg::CH_NUL && r_idx != LAST_POS) begin
                        push_byte        = i_line_rd_data;
                        n_idx            = r_idx + ONE_A;
                        o_line_ctl.rd_en = 1'b1;
                        o_line_rd_addr   = r_idx + ONE_A;
                    end else begin
                        push_byte    = tle_pkg::CH_NUL;
                        push_last    = 1'b1;
                        o_swap       = 1'b1;
                        n_line_ready = 1'b0;
                        n_state      = S_IDLE;
                    end
                end
            end

            S_EMIT: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_byte = seq_byte(r_seq, r_step, r_byte);
                    push_last = seq_last(r_seq, r_step);
                    n_step    = r_step + 2'd1;
                    if (seq_last(r_seq, r_step)) begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (push) begin
            n_out_valid = 1'b1;
            n_out_kind  = push_kind;
            n_out_byte  = push_byte;
            n_out_last  = push_last;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cursor     <= '0;
            r_line_ready <= 1'b0;
            r_esc        <= 1'b0;
            r_drop       <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cursor     <= n_cursor;
            r_line_ready <= n_line_ready;
            r_esc        <= n_esc;
            r_drop       <= n_drop;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_seq      <= n_seq;
        r_step     <= n_step;
        r_byte     <= n_byte;
        r_idx      <= n_idx;
        r_hold     <= n_hold;
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

    `TLE_ASSERT_NOW(a_cursor_range, i_clk, i_rst_n, 1'b1, r_cursor <= LAST_POS)
    `TLE_ASSERT_NOW(a_ready_rewound, i_clk, i_rst_n, r_line_ready, r_cursor == '0)
    `TLE_ASSERT_NOW(a_hold_in_recall, i_clk, i_rst_n, r_hold_valid, r_state == S_RECALL)
    `TLE_ASSERT_NEXT(a_swap_clears_ready, i_clk, i_rst_n, o_swap, !r_line_ready)

endmodule

@@ hdl/terminal_line_editor.sv @@
// Terminal line editor with one-line history: a 64-byte line is edited in
// place from received terminal bytes, echoed back, and delivered on request.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): i_operation = 0 carries a
//   received terminal byte in i_rx_byte; i_operation = 1 takes the ready
//   line. One item is in work at a time; o_in_stall stays high until the
//   sequencer has handed the item's last result to the output register.
//   Result channel (o_out_valid / i_out_stall): o_kind 0 is an echo byte,
//   1 a delivered line byte; o_last marks the final result of an item.
//   Sequence: every item is decoded first; echo items then go on to a line
//   read for a right move and then send their echo bytes in turn; recall and
//   delivery walk the banks at one byte per cycle unless the output stalls,
//   paced by the registered read of the bank RAMs.
//   A stalled receiver holds the output register and freezes the walk;
//   nothing is lost or repeated.
//   Reset: clears cursor, flags and the bank valid bits, so both line and
//   history read as all zero at once; no clearing pass is needed.
//   Taking a line exchanges the roles of the two banks: the delivered line
//   becomes history and the old history bank is cleared to become the line.
`include "terminal_line_editor_assert.svh"

module terminal_line_editor #(
    parameter int LINE_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_operation,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    localparam int AW = $clog2(LINE_BYTES);

    tle_pkg::t_mem_ctl line_ctl;
    logic [AW-1:0]     line_wr_addr;
    logic [7:0]        line_wr_data;
    logic [AW-1:0]     line_rd_addr;
    logic [7:0]        line_rd_data;
    logic              hist_rd_en;
    logic [AW-1:0]     hist_rd_addr;
    logic [7:0]        hist_rd_data;
    logic              swap;

    // which bank currently holds the line being edited
    logic              r_line_bank;

    logic [7:0]        b0_rd_data;
    logic [7:0]        b1_rd_data;
    logic              b0_is_line;
    logic              b1_is_line;

    tle_ctrl #(
        .LINE_BYTES (LINE_BYTES),
        .AW         (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last),
        .o_line_ctl     (line_ctl),
        .o_line_wr_addr (line_wr_addr),
        .o_line_wr_data (line_wr_data),
        .o_line_rd_addr (line_rd_addr),
        .i_line_rd_data (line_rd_data),
        .o_hist_rd_en   (hist_rd_en),
        .o_hist_rd_addr (hist_rd_addr),
        .i_hist_rd_data (hist_rd_data),
        .o_swap         (swap)
    );

    assign b0_is_line = (r_line_bank == 1'b0);
    assign b1_is_line = (r_line_bank == 1'b1);

    // Route the line port to the line bank and the history read to the other;
    // on a swap, clear the history bank as it becomes the new line.
    tle_bank_mem #(
        .DEPTH (LINE_BYTES),
        .AW    (AW)
    ) u_bank0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (swap && !b0_is_line),
        .i_wr_en   (line_ctl.wr_en && b0_is_line),
        .i_wr_addr (line_wr_addr),
        .i_wr_data (line_wr_data),
        .i_rd_en   (b0_is_line ? line_ctl.rd_en : hist_rd_en),
        .i_rd_addr (b0_is_line ? line_rd_addr : hist_rd_addr),
        .o_rd_data (b0_rd_data)
    );

    tle_bank_mem #(
        .DEPTH (LINE_BYTES),
        .AW    (AW)
    ) u_bank1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (swap && !b1_is_line),
        .i_wr_en   (line_ctl.wr_en && b1_is_line),
        .i_wr_addr (line_wr_addr),
        .i_wr_data (line_wr_data),
        .i_rd_en   (b1_is_line ? line_ctl.rd_en : hist_rd_en),
        .i_rd_addr (b1_is_line ? line_rd_addr : hist_rd_addr),
        .o_rd_data (b1_rd_data)
    );

    assign line_rd_data = b1_is_line ? b1_rd_data : b0_rd_data;
    assign hist_rd_data = b1_is_line ? b0_rd_data : b1_rd_data;

    // Flip bank roles when a line is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bank <= 1'b0;
        end else if (swap) begin
            r_line_bank <= !r_line_bank;
        end
    end

    `TLE_ASSERT_NEXT(a_swap_flips_bank, i_clk, i_rst_n, swap, r_line_bank != $past(r_line_bank))
    `TLE_ASSERT_NOW(a_no_write_on_swap, i_clk, i_rst_n, swap, !line_ctl.wr_en && !hist_rd_en)
    `TLE_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_byte))

endmodule
